// File: design/twmm_pkg.sv
`timescale 1ns / 1ps

package twmm_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd1000;

    typedef struct packed {
        logic [TIME_W-1:0]         sample_time;
        logic signed [VALUE_W-1:0] sample_value;
    } twmm_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] window_min;
        logic signed [VALUE_W-1:0] window_max;
        logic [COUNT_W-1:0]        entries_held;
        logic                      overflow_drop;
    } twmm_out_t;

endpackage

// File: design/twmm_front.sv
`timescale 1ns / 1ps

module twmm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  twmm_pkg::twmm_in_t  s_item,
    output logic                q_valid,
    input  logic                q_ready,
    output twmm_pkg::twmm_in_t  q_item
);
    import twmm_pkg::*;

    twmm_in_t    slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// File: design/twmm_back.sv
`timescale 1ns / 1ps

module twmm_back #(
    parameter int WINDOW_DEPTH = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  twmm_pkg::twmm_in_t               q_item,
    input  logic [twmm_pkg::TIME_W-1:0]      window_limit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output twmm_pkg::twmm_out_t              m_item
);
    import twmm_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = TIME_W + VALUE_WIDTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(WINDOW_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_EXP_RD = 3'd2;
    localparam logic [2:0] S_EXP_CK = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [EW-1:0] mem [WINDOW_DEPTH];
    logic [EW-1:0] rdata_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] held_reg, held_next;
    logic          drop_reg, drop_next;
    logic [TIME_W-1:0]             t_reg, t_next;
    logic signed [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic [CW-1:0] fold_reg, fold_next;
    logic          pend_reg, pend_next;
    logic signed [VALUE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [VALUE_WIDTH-1:0] hi_reg, hi_next;
    logic          out_valid_reg, out_valid_next;
    twmm_out_t     out_reg, out_next;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] slot_sum;
    logic signed [63:0] in_ext;
    logic signed [63:0] lo_ext;
    logic signed [63:0] hi_ext;
    logic [TIME_W-1:0]  et;
    logic [TIME_W-1:0]  age;
    logic               expire;
    logic signed [VALUE_WIDTH-1:0] rval;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    assign in_ext = 64'(q_item.sample_value);
    assign lo_ext = 64'(lo_reg);
    assign hi_ext = 64'(hi_reg);
    assign et     = rdata_reg[EW-1:VALUE_WIDTH];
    assign rval   = rdata_reg[VALUE_WIDTH-1:0];
    assign age    = t_reg - et;
    assign expire = (t_reg > et) && (age > window_limit);

    always_comb begin
        slot_sum = SW'(oldest_reg) + SW'(held_reg);
        if (slot_sum >= DEPTH_SUM) begin
            slot_sum = slot_sum - DEPTH_SUM;
        end
    end
    assign wr_addr = slot_sum[AW-1:0];

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        t_next         = t_reg;
        v_next         = v_reg;
        ptr_next       = ptr_reg;
        iss_next       = iss_reg;
        fold_next      = fold_reg;
        pend_next      = 1'b0;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        rd_addr        = oldest_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    t_next    = q_item.sample_time;
                    v_next    = in_ext[VALUE_WIDTH-1:0];
                    drop_next = 1'b0;
                    if (held_reg == FULL_CNT) begin
                        oldest_next = next_slot(oldest_reg);
                        held_next   = FULL_CNT - CW'(1);
                        drop_next   = 1'b1;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                wr_en      = 1'b1;
                held_next  = held_reg + CW'(1);
                state_next = S_EXP_RD;
            end
            S_EXP_RD: begin
                rd_addr = oldest_reg;
                if (held_reg > CW'(1)) begin
                    state_next = S_EXP_CK;
                end else begin
                    ptr_next   = oldest_reg;
                    iss_next   = '0;
                    fold_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_EXP_CK: begin
                if (expire) begin
                    oldest_next = next_slot(oldest_reg);
                    held_next   = held_reg - CW'(1);
                    state_next  = S_EXP_RD;
                end else begin
                    ptr_next   = oldest_reg;
                    iss_next   = '0;
                    fold_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_addr = ptr_reg;
                if (iss_reg < held_reg) begin
                    ptr_next  = next_slot(ptr_reg);
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    fold_next = fold_reg + CW'(1);
                    if (fold_reg == '0) begin
                        lo_next = rval;
                        hi_next = rval;
                    end else begin
                        if (rval < lo_reg) begin
                            lo_next = rval;
                        end
                        if (rval > hi_reg) begin
                            hi_next = rval;
                        end
                    end
                    if (fold_reg + CW'(1) == held_reg) begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next         = 1'b1;
                    out_next.window_min    = lo_ext[VALUE_W-1:0];
                    out_next.window_max    = hi_ext[VALUE_W-1:0];
                    out_next.entries_held  = COUNT_W'(held_reg);
                    out_next.overflow_drop = drop_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            held_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drop_reg <= drop_next;
        t_reg    <= t_next;
        v_reg    <= v_next;
        ptr_reg  <= ptr_next;
        iss_reg  <= iss_next;
        fold_reg <= fold_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {t_reg, v_reg};
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

// File: design/time_window_min_max.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Payload
// input     in         s_valid, s_ready, s_item       sample_time, sample_value
// result    out        m_valid, m_ready, m_item       window_min/max, entries_held, drop
// config    in         cfg_wr_en, cfg_wr_data         window_limit
//
// Each item is written, then the oldest entries are checked for expiry one by one, then the
// held entries are scanned through the single read port of the entry memory.
// A two-entry input queue accepts items while an earlier one is being processed.
// Reset clears the control state; the entry memory holds no reset value.
// A result waits in the output register while m_ready is low.

module time_window_min_max #(
    parameter int WINDOW_DEPTH = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  twmm_pkg::twmm_in_t           s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output twmm_pkg::twmm_out_t          m_item,
    input  logic                         cfg_wr_en,
    input  logic [twmm_pkg::TIME_W-1:0]  cfg_wr_data
);
    import twmm_pkg::*;

    logic              q_valid;
    logic              q_ready;
    twmm_in_t          q_item;
    logic [TIME_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    twmm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    twmm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .window_limit (limit_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule
